@@ rtl/set_assoc_writeback_cache_lru_defines.svh @@
// ----------------------------------------------------------------------------
// Cache tag array assertion macros
// Shared property wrappers for the cache tag and state array.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_WRITEBACK_CACHE_LRU_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_LRU_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAWBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAWBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sawbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Cache tag array package
// Field widths, command codes and transfer payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sawbc_pkg;

    localparam int CMD_W  = 1;
    localparam int ADDR_W = 32;
    localparam int WAY_W  = 2;
    localparam int SET_W  = 6;
    localparam int TAG_W  = 21;
    localparam int CNT_W  = 32;

    localparam logic [CMD_W-1:0] CMD_READ  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  way;
        logic [SET_W-1:0]  set_num;
        logic [TAG_W-1:0]  tag_value;
        logic              write_back;
        logic [CNT_W-1:0]  access_count;
        logic [CNT_W-1:0]  read_count;
        logic [CNT_W-1:0]  write_count;
        logic [CNT_W-1:0]  miss_count;
        logic [CNT_W-1:0]  read_miss_count;
        logic [CNT_W-1:0]  write_miss_count;
        logic [CNT_W-1:0]  write_back_count;
    } t_rsp;

endpackage

`default_nettype wire

@@ rtl/sawbc_stream_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sawbc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/set_assoc_writeback_cache_lru.sv @@
// ----------------------------------------------------------------------------
// Set-associative write-back cache tag array with LRU replacement
// Per-access hit/fill decision, dirty tracking, victim write-back and stats.
// ----------------------------------------------------------------------------
// Each accepted transfer is a read-modify-write of one set row: the row (tags,
// valid, dirty and LRU order) is read from a single synchronous RAM in the
// accept cycle, then compared, updated and written back in S_LOOK, which also
// loads the result register. Input ready stays low until that write-back, so
// a new access is not taken before the last is through; a result still
// waiting on the output holds S_LOOK. After reset the RAM is swept once,
// one set per cycle through all 2**SET_W sets (64 by default), with input
// ready low. Counters in the result are the values after the access is counted.
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_writeback_cache_lru_defines.svh"

module set_assoc_writeback_cache_lru
    import sawbc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    sawbc_stream_if.sink   i_req,
    sawbc_stream_if.source o_rsp
);

    localparam int WAY_BITS      = WAY_W;
    localparam int SET_SEL_BITS  = SET_W;
    localparam int LINE_OFS_BITS = ADDR_W - SET_W - TAG_W;
    localparam int ADDR_BITS     = ADDR_W;

    localparam int NWAYS    = 1 << WAY_BITS;
    localparam int NSETS    = 1 << SET_SEL_BITS;
    localparam int TAG_LEN  = ADDR_BITS - SET_SEL_BITS - LINE_OFS_BITS;
    localparam int WIDX_W   = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int REC_W    = NWAYS * WIDX_W;
    localparam int ROW_W    = NWAYS * TAG_LEN + 2 * NWAYS + REC_W;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [SET_SEL_BITS-1:0] r_clr_idx;
    logic [CMD_W-1:0]        r_cmd;
    logic [SET_SEL_BITS-1:0] r_set;
    logic [TAG_LEN-1:0]      r_tag;

    logic                  r_out_valid;
    logic                  r_hit;
    logic [WAY_W-1:0]      r_way;
    logic [SET_W-1:0]      r_set_out;
    logic [TAG_W-1:0]      r_tag_out;
    logic                  r_wb;

    logic [CNT_W-1:0] r_access_cnt;
    logic [CNT_W-1:0] r_read_cnt;
    logic [CNT_W-1:0] r_write_cnt;
    logic [CNT_W-1:0] r_miss_cnt;
    logic [CNT_W-1:0] r_read_miss_cnt;
    logic [CNT_W-1:0] r_write_miss_cnt;
    logic [CNT_W-1:0] r_wb_cnt;

    logic [ADDR_BITS-1:0]    w_addr;
    logic [SET_SEL_BITS-1:0] w_in_set;
    logic [TAG_LEN-1:0]      w_in_tag;
    logic                    w_accept;
    logic                    w_adv;
    logic                    w_is_write;

    logic [ROW_W-1:0] w_rd_row;
    logic [ROW_W-1:0] w_wr_row;
    logic [ROW_W-1:0] w_clr_row;
    logic             w_ram_we;
    logic [SET_SEL_BITS-1:0] w_ram_waddr;

    logic [NWAYS-1:0][TAG_LEN-1:0]  w_tags, n_tags;
    logic [NWAYS-1:0]               w_valid, n_valid;
    logic [NWAYS-1:0]               w_dirty, n_dirty;
    logic [NWAYS-1:0][WIDX_W-1:0]   w_rec, n_rec, w_clr_rec;

    logic [NWAYS-1:0]  w_match;
    logic              w_hit;
    logic              w_any_free;
    logic [WIDX_W-1:0] w_hit_way;
    logic [WIDX_W-1:0] w_free_way;
    logic [WIDX_W-1:0] w_way;
    logic [WIDX_W-1:0] w_pos;
    logic              w_wb;

    // ---------------- input side ----------------
    assign w_addr     = ADDR_BITS'(i_req.data.address);
    assign w_in_set   = w_addr[LINE_OFS_BITS +: SET_SEL_BITS];
    assign w_in_tag   = w_addr[LINE_OFS_BITS + SET_SEL_BITS +: TAG_LEN];
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_adv      = (r_state == S_LOOK) && (!r_out_valid || o_rsp.ready);
    assign w_is_write = (r_cmd == CMD_WRITE);

    // ---------------- set row RAM ----------------
    assign {w_rec, w_dirty, w_valid, w_tags} = w_rd_row;

    always_comb begin
        for (int k = 0; k < NWAYS; k++) begin
            w_clr_rec[k] = WIDX_W'(k);
        end
    end

    assign w_clr_row   = {w_clr_rec, {(2 * NWAYS + NWAYS * TAG_LEN){1'b0}}};
    assign w_wr_row    = (r_state == S_CLEAR) ? w_clr_row : {n_rec, n_dirty, n_valid, n_tags};
    assign w_ram_we    = (r_state == S_CLEAR) || w_adv;
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_set;

    sawbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_wr_row),
        .i_re    (w_accept),
        .i_raddr (w_in_set),
        .o_rdata (w_rd_row)
    );

    // ---------------- lookup and victim choice ----------------
    always_comb begin
        w_hit_way  = '0;
        w_free_way = '0;
        for (int k = 0; k < NWAYS; k++) begin
            w_match[k] = w_valid[k] && (w_tags[k] == r_tag);
        end
        for (int k = NWAYS - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_hit_way = WIDX_W'(k);
            end
            if (!w_valid[k]) begin
                w_free_way = WIDX_W'(k);
            end
        end
    end

    assign w_hit      = |w_match;
    assign w_any_free = ~&w_valid;
    assign w_way      = w_hit ? w_hit_way : (w_any_free ? w_free_way : w_rec[0]);
    assign w_wb       = !w_hit && w_valid[w_way] && w_dirty[w_way];

    // ---------------- row update ----------------
    always_comb begin
        n_tags  = w_tags;
        n_valid = w_valid;
        n_dirty = w_dirty;
        if (w_hit) begin
            if (w_is_write) begin
                n_dirty[w_way] = 1'b1;
            end
        end else begin
            n_valid[w_way] = 1'b1;
            n_dirty[w_way] = w_is_write;
            n_tags[w_way]  = r_tag;
        end
    end

    // move the used way to the most recent end
    always_comb begin
        w_pos = WIDX_W'(NWAYS - 1);
        for (int k = NWAYS - 1; k >= 0; k--) begin
            if (w_rec[k] == w_way) begin
                w_pos = WIDX_W'(k);
            end
        end
        for (int k = 0; k < NWAYS - 1; k++) begin
            n_rec[k] = (WIDX_W'(k) < w_pos) ? w_rec[k] : w_rec[k + 1];
        end
        n_rec[NWAYS - 1] = w_way;
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == {SET_SEL_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_adv) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.data.cmd;
            r_set <= w_in_set;
            r_tag <= w_in_tag;
        end
        if (w_adv) begin
            r_hit     <= w_hit;
            r_way     <= WAY_W'(w_way);
            r_set_out <= SET_W'(r_set);
            r_tag_out <= TAG_W'(r_tag);
            r_wb      <= w_wb;
        end
    end

    // ---------------- statistics ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_cnt     <= '0;
            r_read_cnt       <= '0;
            r_write_cnt      <= '0;
            r_miss_cnt       <= '0;
            r_read_miss_cnt  <= '0;
            r_write_miss_cnt <= '0;
            r_wb_cnt         <= '0;
        end else if (w_adv) begin
            r_access_cnt <= r_access_cnt + 1'b1;
            if (w_is_write) begin
                r_write_cnt <= r_write_cnt + 1'b1;
            end else begin
                r_read_cnt <= r_read_cnt + 1'b1;
            end
            if (!w_hit) begin
                r_miss_cnt <= r_miss_cnt + 1'b1;
                if (w_is_write) begin
                    r_write_miss_cnt <= r_write_miss_cnt + 1'b1;
                end else begin
                    r_read_miss_cnt <= r_read_miss_cnt + 1'b1;
                end
            end
            if (w_wb) begin
                r_wb_cnt <= r_wb_cnt + 1'b1;
            end
        end
    end

    // ---------------- output side ----------------
    // counters only move when the result register loads
    assign o_rsp.valid                 = r_out_valid;
    assign o_rsp.data.hit              = r_hit;
    assign o_rsp.data.way              = r_way;
    assign o_rsp.data.set_num          = r_set_out;
    assign o_rsp.data.tag_value        = r_tag_out;
    assign o_rsp.data.write_back       = r_wb;
    assign o_rsp.data.access_count     = r_access_cnt;
    assign o_rsp.data.read_count       = r_read_cnt;
    assign o_rsp.data.write_count      = r_write_cnt;
    assign o_rsp.data.miss_count       = r_miss_cnt;
    assign o_rsp.data.read_miss_count  = r_read_miss_cnt;
    assign o_rsp.data.write_miss_count = r_write_miss_cnt;
    assign o_rsp.data.write_back_count = r_wb_cnt;

    // ---------------- assertions ----------------
    `SAWBC_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !i_req.ready, "input ready during clearing sweep")
    `SAWBC_ASSERT_NXT(a_accept_to_look, i_clk, i_rst_n, w_accept, r_state == S_LOOK, "accepted access did not reach lookup")
    `SAWBC_ASSERT_NXT(a_access_count_step, i_clk, i_rst_n, w_adv, r_access_cnt == $past(r_access_cnt) + 1'b1, "access counter did not advance by one")
    `SAWBC_ASSERT_IMP(a_hit_no_wb, i_clk, i_rst_n, r_out_valid, !(r_hit && r_wb), "write-back reported on a hit")

endmodule

`default_nettype wire

@@ rtl/sawbc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sawbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ test/sawbc_cache_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag array checker
// Watches the request and response channels and keeps its own model of
// the tags, valid, dirty and LRU state and the statistics counters. Every
// accepted request yields a predicted lookup, and every accepted response
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module sawbc_cache_checker
    import sawbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NWAYS = 1 << WAY_W;
    localparam int NSETS = 1 << SET_W;
    localparam int OFF_W = ADDR_W - SET_W - TAG_W;

    logic             line_valid [NSETS][NWAYS];
    logic             line_dirty [NSETS][NWAYS];
    logic [TAG_W-1:0] line_tag   [NSETS][NWAYS];
    logic [WAY_W-1:0] lru_order  [NSETS][NWAYS];

    logic [CNT_W-1:0] n_access;
    logic [CNT_W-1:0] n_read;
    logic [CNT_W-1:0] n_write;
    logic [CNT_W-1:0] n_miss;
    logic [CNT_W-1:0] n_read_miss;
    logic [CNT_W-1:0] n_write_miss;
    logic [CNT_W-1:0] n_write_back;

    t_rsp predicted_lookups [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_rsp lookup_and_update(input t_req r);
        t_rsp             p;
        logic [SET_W-1:0] s;
        logic [TAG_W-1:0] tg;
        logic [WAY_W-1:0] w;
        logic             found;
        logic             is_wr;
        int               pos;
        s     = r.address[OFF_W +: SET_W];
        tg    = r.address[OFF_W+SET_W +: TAG_W];
        is_wr = (r.cmd == CMD_WRITE);
        p     = '0;
        found = 1'b0;
        w     = '0;

        n_access = n_access + 1;
        if (is_wr) n_write = n_write + 1;
        else       n_read  = n_read + 1;

        for (int i = 0; i < NWAYS; i++) begin
            if (!found && line_valid[s][i] && line_tag[s][i] == tg) begin
                found = 1'b1;
                w     = WAY_W'(i);
            end
        end
        p.hit = found;

        if (found) begin
            if (is_wr) line_dirty[s][w] = 1'b1;
        end else begin
            for (int i = 0; i < NWAYS; i++) begin
                if (!found && !line_valid[s][i]) begin
                    found = 1'b1;
                    w     = WAY_W'(i);
                end
            end
            if (!found) w = lru_order[s][0];
            if (line_valid[s][w] && line_dirty[s][w]) begin
                p.write_back = 1'b1;
                n_write_back = n_write_back + 1;
            end
            line_valid[s][w] = 1'b1;
            line_dirty[s][w] = is_wr;
            line_tag[s][w]   = tg;
            n_miss = n_miss + 1;
            if (is_wr) n_write_miss = n_write_miss + 1;
            else       n_read_miss  = n_read_miss + 1;
        end

        // move the used way to the most recent end
        pos = 0;
        while (pos < NWAYS - 1 && lru_order[s][pos] != w) pos++;
        for (int k = pos; k < NWAYS - 1; k++) lru_order[s][k] = lru_order[s][k+1];
        lru_order[s][NWAYS-1] = w;

        p.way              = w;
        p.set_num          = s;
        p.tag_value        = tg;
        p.access_count     = n_access;
        p.read_count       = n_read;
        p.write_count      = n_write;
        p.miss_count       = n_miss;
        p.read_miss_count  = n_read_miss;
        p.write_miss_count = n_write_miss;
        p.write_back_count = n_write_back;
        return p;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                               input logic [CNT_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_rsp exp_r;
        if (!i_rst_n) begin
            for (int s = 0; s < NSETS; s++) begin
                for (int w = 0; w < NWAYS; w++) begin
                    line_valid[s][w] = 1'b0;
                    line_dirty[s][w] = 1'b0;
                    line_tag[s][w]   = '0;
                    lru_order[s][w]  = WAY_W'(w);
                end
            end
            n_access     = '0;
            n_read       = '0;
            n_write      = '0;
            n_miss       = '0;
            n_read_miss  = '0;
            n_write_miss = '0;
            n_write_back = '0;
            predicted_lookups.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (predicted_lookups.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    o_fail_count++;
                end else begin
                    exp_r = predicted_lookups.pop_front();
                    check_field("hit", exp_r.hit, i_rsp_data.hit);
                    check_field("way", exp_r.way, i_rsp_data.way);
                    check_field("set_num", exp_r.set_num, i_rsp_data.set_num);
                    check_field("tag_value", exp_r.tag_value, i_rsp_data.tag_value);
                    check_field("write_back", exp_r.write_back, i_rsp_data.write_back);
                    check_field("access_count", exp_r.access_count,
                                i_rsp_data.access_count);
                    check_field("read_count", exp_r.read_count, i_rsp_data.read_count);
                    check_field("write_count", exp_r.write_count, i_rsp_data.write_count);
                    check_field("miss_count", exp_r.miss_count, i_rsp_data.miss_count);
                    check_field("read_miss_count", exp_r.read_miss_count,
                                i_rsp_data.read_miss_count);
                    check_field("write_miss_count", exp_r.write_miss_count,
                                i_rsp_data.write_miss_count);
                    check_field("write_back_count", exp_r.write_back_count,
                                i_rsp_data.write_back_count);
                end
            end
            if (i_req_valid && i_req_ready) begin
                predicted_lookups.push_back(lookup_and_update(i_req_data));
            end
        end
        o_pending = predicted_lookups.size();
    end

endmodule

@@ test/tb_set_assoc_writeback_cache_lru.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag array testbench
// Drives directed and random read/write accesses into the cache tag array,
// concentrated on a few sets and tags so that hits, fills, LRU evictions and
// dirty write-backs are frequent, under three idle patterns on both channels.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------

module tb_set_assoc_writeback_cache_lru;
    import sawbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 630;
    localparam int OFF_W = ADDR_W - SET_W - TAG_W;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   stall_cycles;

    logic [TAG_W-1:0] tag_pool [8];
    logic [SET_W-1:0] hot_sets [4];

    sawbc_stream_if #(.T(t_req)) req_if ();
    sawbc_stream_if #(.T(t_rsp)) rsp_if ();

    set_assoc_writeback_cache_lru dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    sawbc_cache_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_data   (req_if.data),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_rsp_data   (rsp_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tg,
                                                   input logic [SET_W-1:0] s,
                                                   input logic [OFF_W-1:0] off);
        return {tg, s, off};
    endfunction

    task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.data.cmd     <= cmd;
        req_if.data.address <= addr;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // response side back-pressure
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int               mode;
        logic [SET_W-1:0] s;
        logic [TAG_W-1:0] tg;
        logic [ADDR_W-1:0] addr;
        stall_cycles  = 0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        send_idle_pct = 38;
        recv_idle_pct = 83;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes of the address, read/write miss and hit
        send_access(CMD_READ,  32'h0000_0000);
        send_access(CMD_WRITE, 32'hFFFF_FFFF);
        send_access(CMD_READ,  32'hFFFF_FFFF);
        send_access(CMD_WRITE, 32'h0000_001F);
        // fill one set, then evict clean and dirty victims in LRU order
        send_access(CMD_WRITE, make_addr(21'd1, 6'd5, 5'd0));
        send_access(CMD_READ,  make_addr(21'd2, 6'd5, 5'd3));
        send_access(CMD_WRITE, make_addr(21'd3, 6'd5, 5'd7));
        send_access(CMD_READ,  make_addr(21'd4, 6'd5, 5'd31));
        send_access(CMD_READ,  make_addr(21'd1, 6'd5, 5'd9));
        send_access(CMD_READ,  make_addr(21'd5, 6'd5, 5'd0));
        send_access(CMD_WRITE, make_addr(21'd6, 6'd5, 5'd0));
        send_access(CMD_READ,  make_addr(21'd7, 6'd5, 5'd0));
        send_access(CMD_READ,  make_addr(21'd8, 6'd5, 5'd0));
        send_access(CMD_WRITE, make_addr(21'd6, 6'd5, 5'd1));
        send_access(CMD_READ,  make_addr(21'h1F_FFFF, 6'd0, 5'd0));
        send_access(CMD_WRITE, make_addr(21'h0, 6'd63, 5'd31));
        // same set and tag back to back
        send_access(CMD_WRITE, make_addr(21'h15_5555, 6'd42, 5'd10));
        send_access(CMD_READ,  make_addr(21'h15_5555, 6'd42, 5'd21));
        send_access(CMD_WRITE, make_addr(21'h15_5555, 6'd42, 5'd0));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 38; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 100 == 0) begin
                    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom());
                    foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom());
                end
                mode = $urandom_range(0, 99);
                s    = (mode < 80) ? hot_sets[$urandom_range(0, 3)] : SET_W'($urandom());
                tg   = tag_pool[$urandom_range(0, 7)];
                addr = (mode < 95) ? make_addr(tg, s, OFF_W'($urandom())) : $urandom();
                send_access(CMD_W'($urandom_range(0, 1)), addr);
            end
        end
        req_if.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sawbc_pkg.sv
rtl/sawbc_stream_if.sv
rtl/sawbc_ram.sv
rtl/set_assoc_writeback_cache_lru.sv
test/sawbc_cache_checker.sv
test/tb_set_assoc_writeback_cache_lru.sv
